### rtl/rgzm_pkg.sv
package rgzm_pkg;

    localparam logic [16:0] DEFAULT_GROUP_SIZE = 17'd4096;
    localparam logic [31:0] ROW_INDEX_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [63:0] fingerprint;
        logic [63:0] length;
        logic [15:0] completeness;
        logic [15:0] contamination;
        logic [31:0] flags;
    } row_t;

    typedef struct packed {
        logic [63:0] fp_min;
        logic [63:0] fp_max;
        logic [63:0] len_min;
        logic [63:0] len_max;
        logic [15:0] comp_min;
        logic [15:0] comp_max;
        logic [15:0] cont_min;
        logic [15:0] cont_max;
        logic [31:0] flags;
    } stats_t;

endpackage

### rtl/rgzm_fold.sv
module rgzm_fold (
    input  logic            first,
    input  rgzm_pkg::stats_t stats_in,
    input  rgzm_pkg::row_t   row,
    output rgzm_pkg::stats_t stats_out
);
    import rgzm_pkg::*;

    stats_t base;

    // first row of a group seeds the bounds and clears the flag union
    always_comb begin
        if (first) begin
            base.fp_min   = row.fingerprint;
            base.fp_max   = row.fingerprint;
            base.len_min  = row.length;
            base.len_max  = row.length;
            base.comp_min = row.completeness;
            base.comp_max = row.completeness;
            base.cont_min = row.contamination;
            base.cont_max = row.contamination;
            base.flags    = 32'd0;
        end else begin
            base = stats_in;
        end
    end

    always_comb begin
        stats_out.fp_min   = (row.fingerprint < base.fp_min) ? row.fingerprint : base.fp_min;
        stats_out.fp_max   = (row.fingerprint > base.fp_max) ? row.fingerprint : base.fp_max;
        stats_out.len_min  = (row.length < base.len_min) ? row.length : base.len_min;
        stats_out.len_max  = (row.length > base.len_max) ? row.length : base.len_max;
        stats_out.comp_min = (row.completeness < base.comp_min) ?
                             row.completeness : base.comp_min;
        stats_out.comp_max = (row.completeness > base.comp_max) ?
                             row.completeness : base.comp_max;
        stats_out.cont_min = (row.contamination < base.cont_min) ?
                             row.contamination : base.cont_min;
        stats_out.cont_max = (row.contamination > base.cont_max) ?
                             row.contamination : base.cont_max;
        stats_out.flags    = base.flags | row.flags;
    end

endmodule

### rtl/row_group_zone_map_builder.sv
// the record of a group is registered and valid in the cycle after its closing row is accepted
// throughput: one row per cycle; s_ready drops only while a record waits in the
//   output register and m_ready is low
// the fold of a row into the running statistics is one pass of compare/select logic
// reset (aresetn low, synchronous): group_size returns to 4096, row index, group row
//   count and the output valid clear; no clearing pass, ready on the next cycle
module row_group_zone_map_builder #(
    parameter int MAX_GROUP_ROWS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_group_size,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_row_fingerprint,
    input  logic [63:0] s_row_length,
    input  logic [15:0] s_row_completeness,
    input  logic [15:0] s_row_contamination,
    input  logic [31:0] s_row_flags,
    input  logic        s_row_deleted,
    input  logic        s_row_is_final,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_group_first_row,
    output logic [31:0] m_group_last_row,
    output logic [63:0] m_fingerprint_min,
    output logic [63:0] m_fingerprint_max,
    output logic [63:0] m_length_min,
    output logic [63:0] m_length_max,
    output logic [15:0] m_completeness_min,
    output logic [15:0] m_completeness_max,
    output logic [15:0] m_contamination_min,
    output logic [15:0] m_contamination_max,
    output logic [31:0] m_flags_union,
    output logic [16:0] m_live_rows
);
    import rgzm_pkg::*;

    localparam int CW = $clog2(MAX_GROUP_ROWS + 1);
    localparam int EW = (CW > 17) ? CW : 17;
    localparam logic [EW-1:0] MAX_ROWS = EW'(MAX_GROUP_ROWS);

    logic [16:0]   group_size_reg;
    logic [31:0]   row_index_reg, row_index_next;
    logic [31:0]   group_start_reg, group_start_next;
    logic [CW-1:0] rows_reg, rows_next;
    logic [CW-1:0] live_reg, live_next;
    stats_t        stats_reg, stats_next;

    logic          m_valid_reg;
    logic [31:0]   out_first_reg, out_last_reg;
    stats_t        out_stats_reg;
    logic [16:0]   out_live_reg;

    row_t          row;
    logic          first;
    logic [EW-1:0] size_eff;
    logic          close;
    logic          accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign row.fingerprint   = s_row_fingerprint;
    assign row.length        = s_row_length;
    assign row.completeness  = s_row_completeness;
    assign row.contamination = s_row_contamination;
    assign row.flags         = s_row_flags;

    assign first = (rows_reg == '0);

    rgzm_fold u_fold (
        .first     (first),
        .stats_in  (stats_reg),
        .row       (row),
        .stats_out (stats_next)
    );

    // zero acts as one, anything above the build limit acts as the limit
    always_comb begin
        if (group_size_reg == 17'd0) begin
            size_eff = EW'(1);
        end else if (EW'(group_size_reg) > MAX_ROWS) begin
            size_eff = MAX_ROWS;
        end else begin
            size_eff = EW'(group_size_reg);
        end
    end

    always_comb begin
        group_start_next = first ? row_index_reg : group_start_reg;
        live_next        = (first ? '0 : live_reg) + CW'(!s_row_deleted);
        rows_next        = rows_reg + CW'(1);
        close            = s_row_is_final || (EW'(rows_next) >= size_eff);
        if (s_row_is_final) begin
            row_index_next = 32'd0;
        end else if (row_index_reg != ROW_INDEX_MAX) begin
            row_index_next = row_index_reg + 32'd1;
        end else begin
            row_index_next = row_index_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= DEFAULT_GROUP_SIZE;
            row_index_reg  <= 32'd0;
            rows_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                group_size_reg <= cfg_group_size;
            end
            if (accept && close) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                row_index_reg <= row_index_next;
                rows_reg      <= close ? '0 : rows_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            group_start_reg <= group_start_next;
            live_reg        <= live_next;
            stats_reg       <= stats_next;
            if (close) begin
                out_first_reg <= group_start_next;
                out_last_reg  <= row_index_reg;
                out_stats_reg <= stats_next;
                out_live_reg  <= 17'(live_next);
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_group_first_row   = out_first_reg;
    assign m_group_last_row    = out_last_reg;
    assign m_fingerprint_min   = out_stats_reg.fp_min;
    assign m_fingerprint_max   = out_stats_reg.fp_max;
    assign m_length_min        = out_stats_reg.len_min;
    assign m_length_max        = out_stats_reg.len_max;
    assign m_completeness_min  = out_stats_reg.comp_min;
    assign m_completeness_max  = out_stats_reg.comp_max;
    assign m_contamination_min = out_stats_reg.cont_min;
    assign m_contamination_max = out_stats_reg.cont_max;
    assign m_flags_union       = out_stats_reg.flags;
    assign m_live_rows         = out_live_reg;

endmodule

### rtl/rgzm_checker.sv
module rgzm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_row_is_final,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_group_first_row,
    input logic [31:0] m_group_last_row,
    input logic [63:0] m_fingerprint_min,
    input logic [63:0] m_fingerprint_max,
    input logic [63:0] m_length_min,
    input logic [63:0] m_length_max,
    input logic [15:0] m_completeness_min,
    input logic [15:0] m_completeness_max,
    input logic [15:0] m_contamination_min,
    input logic [15:0] m_contamination_max
);

    // a waiting record stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_group_first_row)
            && $stable(m_group_last_row) && $stable(m_fingerprint_min))
        else $error("record dropped or changed while stalled");

    // a final row always closes its group
    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_row_is_final |=> m_valid)
        else $error("final row produced no record");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_group_first_row <= m_group_last_row)
        else $error("group first row after last row");

    // bounds are seeded from the first row, so min never exceeds max
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fingerprint_min <= m_fingerprint_max
            && m_length_min <= m_length_max
            && m_completeness_min <= m_completeness_max
            && m_contamination_min <= m_contamination_max)
        else $error("min above max in record");

endmodule

bind row_group_zone_map_builder rgzm_checker u_rgzm_checker (.*);

### verif/zone_map_checker.sv
`timescale 1ns / 1ps

module zone_map_checker #(
    parameter int MAX_GROUP_ROWS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [16:0] cfg_group_size,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_row_fingerprint,
    input  logic [63:0] s_row_length,
    input  logic [15:0] s_row_completeness,
    input  logic [15:0] s_row_contamination,
    input  logic [31:0] s_row_flags,
    input  logic        s_row_deleted,
    input  logic        s_row_is_final,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_group_first_row,
    input  logic [31:0] m_group_last_row,
    input  logic [63:0] m_fingerprint_min,
    input  logic [63:0] m_fingerprint_max,
    input  logic [63:0] m_length_min,
    input  logic [63:0] m_length_max,
    input  logic [15:0] m_completeness_min,
    input  logic [15:0] m_completeness_max,
    input  logic [15:0] m_contamination_min,
    input  logic [15:0] m_contamination_max,
    input  logic [31:0] m_flags_union,
    input  logic [16:0] m_live_rows,

    output int          mismatches,
    output int          pending
);

    import rgzm_pkg::*;

    typedef struct packed {
        logic [31:0] start_row;
        logic [31:0] end_row;
        stats_t      stats;
        logic [16:0] live_rows;
    } zone_record_t;

    logic [16:0]  group_size;
    logic [31:0]  row_idx;
    logic [31:0]  group_start;
    logic [31:0]  rows_held;
    logic [31:0]  live_tally;
    stats_t       running;
    zone_record_t expected_records[$];

    function automatic int unsigned effective_group_size();
        if (group_size == 17'd0) return 1;
        if (group_size > MAX_GROUP_ROWS) return MAX_GROUP_ROWS;
        return 32'(group_size);
    endfunction

    task automatic fold_row(input row_t r, input logic deleted, input logic is_last);
        zone_record_t rec;
        // first row of a group seeds every bound
        if (rows_held == 0) begin
            group_start      = row_idx;
            running.fp_min   = r.fingerprint;
            running.fp_max   = r.fingerprint;
            running.len_min  = r.length;
            running.len_max  = r.length;
            running.comp_min = r.completeness;
            running.comp_max = r.completeness;
            running.cont_min = r.contamination;
            running.cont_max = r.contamination;
            running.flags    = '0;
            live_tally       = '0;
        end
        if (r.fingerprint < running.fp_min) running.fp_min = r.fingerprint;
        if (r.fingerprint > running.fp_max) running.fp_max = r.fingerprint;
        if (r.length < running.len_min) running.len_min = r.length;
        if (r.length > running.len_max) running.len_max = r.length;
        if (r.completeness < running.comp_min) running.comp_min = r.completeness;
        if (r.completeness > running.comp_max) running.comp_max = r.completeness;
        if (r.contamination < running.cont_min) running.cont_min = r.contamination;
        if (r.contamination > running.cont_max) running.cont_max = r.contamination;
        running.flags |= r.flags;
        if (!deleted && live_tally != '1) live_tally++;
        if (rows_held != '1) rows_held++;

        if (is_last || rows_held >= effective_group_size()) begin
            rec.start_row = group_start;
            rec.end_row   = row_idx;
            rec.stats     = running;
            rec.live_rows = live_tally[16:0];
            expected_records.insert(expected_records.size(), rec);
            rows_held     = '0;
            running.flags = '0;
            live_tally    = '0;
        end

        // a final row starts a new table, otherwise the index saturates
        if (is_last) row_idx = '0;
        else if (row_idx != ROW_INDEX_MAX) row_idx++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        zone_record_t want;
        row_t         row;
        if (!aresetn) begin
            group_size  = DEFAULT_GROUP_SIZE;
            row_idx     = '0;
            group_start = '0;
            rows_held   = '0;
            live_tally  = '0;
            running     = '0;
            expected_records.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_records.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: group record with none expected, rows %0d..%0d",
                                 $time, m_group_first_row, m_group_last_row);
                end else begin
                    want = expected_records.pop_front();
                    check_field("group_first_row", 64'(want.start_row),
                                64'(m_group_first_row));
                    check_field("group_last_row", 64'(want.end_row),
                                64'(m_group_last_row));
                    check_field("fingerprint_min", want.stats.fp_min, m_fingerprint_min);
                    check_field("fingerprint_max", want.stats.fp_max, m_fingerprint_max);
                    check_field("length_min", want.stats.len_min, m_length_min);
                    check_field("length_max", want.stats.len_max, m_length_max);
                    check_field("comp_min", 64'(want.stats.comp_min),
                                64'(m_completeness_min));
                    check_field("comp_max", 64'(want.stats.comp_max),
                                64'(m_completeness_max));
                    check_field("cont_min", 64'(want.stats.cont_min),
                                64'(m_contamination_min));
                    check_field("cont_max", 64'(want.stats.cont_max),
                                64'(m_contamination_max));
                    check_field("flags_union", 64'(want.stats.flags), 64'(m_flags_union));
                    check_field("live_rows", 64'(want.live_rows), 64'(m_live_rows));
                end
            end
            if (cfg_valid && cfg_ready) group_size = cfg_group_size;
            if (s_valid && s_ready) begin
                row.fingerprint   = s_row_fingerprint;
                row.length        = s_row_length;
                row.completeness  = s_row_completeness;
                row.contamination = s_row_contamination;
                row.flags         = s_row_flags;
                fold_row(row, s_row_deleted, s_row_is_final);
            end
        end
        pending = expected_records.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    import rgzm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        row_t data;
        logic deleted;
        logic is_last;
    } table_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_group_size;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_row_fingerprint;
    logic [63:0] s_row_length;
    logic [15:0] s_row_completeness;
    logic [15:0] s_row_contamination;
    logic [31:0] s_row_flags;
    logic        s_row_deleted;
    logic        s_row_is_final;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_group_first_row;
    logic [31:0] m_group_last_row;
    logic [63:0] m_fingerprint_min;
    logic [63:0] m_fingerprint_max;
    logic [63:0] m_length_min;
    logic [63:0] m_length_max;
    logic [15:0] m_completeness_min;
    logic [15:0] m_completeness_max;
    logic [15:0] m_contamination_min;
    logic [15:0] m_contamination_max;
    logic [31:0] m_flags_union;
    logic [16:0] m_live_rows;

    int mismatches;
    int pending;
    int cycles;
    int hold_request;
    bit source_burst;
    bit sink_burst;

    row_group_zone_map_builder uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_group_size      (cfg_group_size),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_row_fingerprint   (s_row_fingerprint),
        .s_row_length        (s_row_length),
        .s_row_completeness  (s_row_completeness),
        .s_row_contamination (s_row_contamination),
        .s_row_flags         (s_row_flags),
        .s_row_deleted       (s_row_deleted),
        .s_row_is_final      (s_row_is_final),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_group_first_row   (m_group_first_row),
        .m_group_last_row    (m_group_last_row),
        .m_fingerprint_min   (m_fingerprint_min),
        .m_fingerprint_max   (m_fingerprint_max),
        .m_length_min        (m_length_min),
        .m_length_max        (m_length_max),
        .m_completeness_min  (m_completeness_min),
        .m_completeness_max  (m_completeness_max),
        .m_contamination_min (m_contamination_min),
        .m_contamination_max (m_contamination_max),
        .m_flags_union       (m_flags_union),
        .m_live_rows         (m_live_rows)
    );

    zone_map_checker zone_check (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                m_ready = 1'b0;
                repeat (hold_request) @(negedge aclk);
                hold_request = 0;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (!sink_burst && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                stall_left = pick_gap();
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand_wide();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'($urandom_range(0, 255));
            3: return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] rand_score();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 16'($urandom_range(0, 1000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_flags();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom & $urandom;
        endcase
    endfunction

    function automatic table_row_t random_row(int last_pct);
        table_row_t r;
        r.data.fingerprint   = rand_wide();
        r.data.length        = rand_wide();
        r.data.completeness  = rand_score();
        r.data.contamination = rand_score();
        r.data.flags         = rand_flags();
        r.deleted            = ($urandom_range(0, 3) == 0);
        r.is_last            = ($urandom_range(0, 99) < last_pct);
        return r;
    endfunction

    function automatic table_row_t make_row(logic [63:0] fp, logic [63:0] len,
                                            logic [15:0] comp, logic [15:0] cont,
                                            logic [31:0] flags, logic deleted,
                                            logic is_last);
        table_row_t r;
        r.data.fingerprint   = fp;
        r.data.length        = len;
        r.data.completeness  = comp;
        r.data.contamination = cont;
        r.data.flags         = flags;
        r.deleted            = deleted;
        r.is_last            = is_last;
        return r;
    endfunction

    task automatic send_row(input table_row_t r);
        int gap;
        gap = source_burst ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid             = 1'b1;
        s_row_fingerprint   = r.data.fingerprint;
        s_row_length        = r.data.length;
        s_row_completeness  = r.data.completeness;
        s_row_contamination = r.data.contamination;
        s_row_flags         = r.data.flags;
        s_row_deleted       = r.deleted;
        s_row_is_final      = r.is_last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // all records in, then a wait for a row that closes nothing
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        wait (pending == 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_group_size(input logic [16:0] size);
        @(negedge aclk);
        cfg_valid      = 1'b1;
        cfg_group_size = size;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [16:0] phase_group_size(int phase);
        case (phase)
            0: return 17'd1;
            1: return 17'd3;
            2: return 17'd0;
            3: return 17'd1;
            4: return 17'd7;
            5: return 17'($urandom_range(2, 16));
            6: return 17'($urandom_range(65537, 131071));
            7: return 17'd50;
            default: return 17'd65536;
        endcase
    endfunction

    initial begin
        logic [16:0] size;
        aresetn             = 1'b0;
        cfg_valid           = 1'b0;
        cfg_group_size      = '0;
        s_valid             = 1'b0;
        s_row_fingerprint   = '0;
        s_row_length        = '0;
        s_row_completeness  = '0;
        s_row_contamination = '0;
        s_row_flags         = '0;
        s_row_deleted       = 1'b0;
        s_row_is_final      = 1'b0;
        hold_request        = 0;
        source_burst        = 1'b0;
        sink_burst          = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // reset group size, extremes of every field, table closed by a final row
        send_row(make_row('0, '1, '0, '1, '0, 1'b0, 1'b0));
        send_row(make_row('1, '0, '1, '0, '1, 1'b1, 1'b0));
        send_row(make_row(64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe,
                          16'h8000, 16'h7fff, 32'h5a5a_a5a5, 1'b1, 1'b1));

        // zero group size behaves as one row per group
        wait_idle();
        set_group_size(17'd0);
        send_row(make_row(64'd5, 64'd9, 16'd3, 16'd4, 32'h1, 1'b0, 1'b0));
        send_row(make_row(64'd2, 64'd1, 16'd7, 16'd1, 32'h2, 1'b1, 1'b1));

        // oversized group size, only the final row closes
        wait_idle();
        set_group_size('1);
        send_row(make_row(64'd100, 64'd30, 16'd500, 16'd20, 32'h10, 1'b0, 1'b0));
        send_row(make_row(64'd50, 64'd70, 16'd900, 16'd5, 32'h100, 1'b0, 1'b0));
        send_row(make_row(64'd75, 64'd10, 16'd100, 16'd60, 32'h1000, 1'b1, 1'b1));

        // size shrinks under an open group, the next row closes it
        wait_idle();
        set_group_size(17'd6);
        repeat (4) send_row(random_row(0));
        wait_idle();
        set_group_size(17'd2);
        repeat (3) send_row(random_row(0));
        send_row(random_row(100));

        wait_idle();
        set_group_size(17'd1);
        send_row(make_row('1, '1, '1, '1, '1, 1'b1, 1'b0));
        send_row(make_row('0, '0, '0, '0, '0, 1'b0, 1'b1));

        for (int phase = 0; phase < 9; phase++) begin
            wait_idle();
            size = phase_group_size(phase);
            set_group_size(size);
            source_burst = (phase == 2);
            sink_burst   = (phase == 2);
            if (phase == 3) begin
                // receiver holds off while rows keep coming
                hold_request = 200;
                source_burst = 1'b1;
                repeat (40) send_row(random_row(4));
                source_burst = 1'b0;
            end
            for (int i = 0; i < 100; i++) begin
                send_row(random_row((size >= 17'd50 || size == 17'd0) ? 6 : 4));
                if (phase == 5 && i == 50) begin
                    @(negedge aclk);
                    s_valid = 1'b0;
                    wait (pending == 0);
                end
            end
        end
        source_burst = 1'b0;
        sink_burst   = 1'b0;

        wait_idle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
